FILE: design/mte_pkg.sv
// shared types and constants for the multi-tap echo block
`default_nettype none

package mte_pkg;

   localparam int SAMPLE_W    = 16;
   localparam int STORE_DEPTH = 32768;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int SEEN_W      = ADDR_W + 1;
   localparam int DIST_W      = SEEN_W;

   localparam int DELAY_W  = 13;
   localparam int BOUNCE_W = 4;
   localparam int FB_W     = 7;
   localparam int GAIN_W   = 15;
   localparam int CSR_W    = 13;
   localparam int CSR_IDX_W = 2;

   localparam logic [DELAY_W-1:0]  MAX_DELAY  = DELAY_W'(4096);
   localparam logic [BOUNCE_W-1:0] MAX_BOUNCE = BOUNCE_W'(8);
   localparam logic [FB_W-1:0]     FB_MAX     = FB_W'(100);
   localparam logic [SEEN_W-1:0]   SEEN_MAX   = SEEN_W'(STORE_DEPTH);

   // floor(fb * 32767 / 100) == (fb * GAIN_RECIP) >> 16 for fb in 0..100
   localparam logic [31:0] GAIN_RECIP = 32'd21474182;

   localparam logic signed [SAMPLE_W-1:0] SAT_MAX = 16'sh7fff;
   localparam logic signed [SAMPLE_W-1:0] SAT_MIN = -16'sh8000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DELAY    = 2'd0,
      CSR_BOUNCE   = 2'd1,
      CSR_FEEDBACK = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_MULT,
      ST_ACCUM,
      ST_STORE
   } state_type;

   typedef enum logic [1:0] {
      TAP_ZERO,
      TAP_HIST,
      TAP_CURRENT
   } tap_src_type;

   typedef struct packed {
      logic load;
      logic read;
      logic mult;
      logic accum;
      logic store;
   } ctl_cmd_type;

   typedef struct packed {
      logic [BOUNCE_W-1:0] bounce_limit;
   } dp_status_type;

endpackage

`default_nettype wire

FILE: design/mte_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none

module mte_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

FILE: design/mte_ctrl.sv
// controller state machine sequencing the taps of one sample
`default_nettype none

module mte_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   input  wire mte_pkg::dp_status_type status,
   output mte_pkg::ctl_cmd_type        cmd
);

   import mte_pkg::*;

   state_type             state_ff, state_in;
   logic [BOUNCE_W-1:0]   tap_cnt_ff, tap_cnt_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  accept;
   logic                  last_tap;
   logic                  store_go;

   assign accept   = (state_ff == ST_IDLE) && req_tvalid;
   assign last_tap = (tap_cnt_ff == status.bounce_limit);
   assign store_go = (state_ff == ST_STORE) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = (status.bounce_limit == '0) ? ST_STORE : ST_READ;
            end
         end
         ST_READ:  state_in = ST_MULT;
         ST_MULT:  state_in = ST_ACCUM;
         ST_ACCUM: state_in = last_tap ? ST_STORE : ST_READ;
         ST_STORE: begin
            if (store_go) begin
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         ST_READ:  cmd.read  = 1'b1;
         ST_MULT:  cmd.mult  = 1'b1;
         ST_ACCUM: cmd.accum = 1'b1;
         ST_STORE: cmd.store = store_go;
         default: begin
            cmd        = '0;
            req_tready = 1'b0;
         end
      endcase
   end

   always_comb begin
      tap_cnt_in = tap_cnt_ff;
      if (accept) begin
         tap_cnt_in = BOUNCE_W'(1);
      end else if (state_ff == ST_ACCUM && !last_tap) begin
         tap_cnt_in = tap_cnt_ff + BOUNCE_W'(1);
      end
   end

   // output register: loaded on store, freed by the receiver
   always_comb begin
      if (store_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tap_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tap_cnt_ff   <= tap_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

FILE: design/mte_datapath.sv
// datapath: settings, history store, tap multiplier and saturating accumulator
`default_nettype none

module mte_datapath (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_we,
   input  wire logic [mte_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire logic [mte_pkg::CSR_W-1:0]            csr_wdata,
   input  wire logic signed [mte_pkg::SAMPLE_W-1:0]  sample_in,
   input  wire logic                                 last_in,
   input  wire mte_pkg::ctl_cmd_type                 cmd,
   output mte_pkg::dp_status_type                    status,
   output logic signed [mte_pkg::SAMPLE_W-1:0]       sample_out,
   output logic                                      last_out
);

   import mte_pkg::*;

   logic [DELAY_W-1:0]  delay_ff;
   logic [BOUNCE_W-1:0] bounce_ff;
   logic [FB_W-1:0]     fb_ff;

   logic [DELAY_W-1:0]  delay_use;
   logic [FB_W-1:0]     fb_use;
   logic [31:0]         gain_wide;
   logic [GAIN_W-1:0]   gain_now;
   logic [GAIN_W-1:0]   gain_ff;

   logic signed [SAMPLE_W-1:0] x_ff;
   logic                       last_ff;
   logic [ADDR_W-1:0]          wp_ff, wp_in;
   logic [SEEN_W-1:0]          seen_ff, seen_in;
   logic [DIST_W-1:0]          dist_ff;
   logic [GAIN_W-1:0]          power_ff;
   logic signed [SAMPLE_W-1:0] acc_ff;
   logic signed [SAMPLE_W-1:0] prod_ff;
   tap_src_type                tap_src_ff, tap_src_in;

   logic signed [SAMPLE_W-1:0] sample_out_ff;
   logic                       last_out_ff;

   logic [ADDR_W-1:0]          rd_addr;
   logic [SAMPLE_W-1:0]        rd_data;
   logic signed [SAMPLE_W-1:0] tap_val;
   logic signed [31:0]         tap_prod;
   logic [2*GAIN_W-1:0]        power_prod;
   logic signed [SAMPLE_W:0]   acc_sum;
   logic signed [SAMPLE_W-1:0] acc_sat;

   // settings, clamped at use
   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff  <= '0;
         bounce_ff <= '0;
         fb_ff     <= '0;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_DELAY:    delay_ff  <= csr_wdata[DELAY_W-1:0];
            CSR_BOUNCE:   bounce_ff <= csr_wdata[BOUNCE_W-1:0];
            CSR_FEEDBACK: fb_ff     <= csr_wdata[FB_W-1:0];
            default: ;
         endcase
      end
   end

   assign delay_use           = (delay_ff > MAX_DELAY) ? MAX_DELAY : delay_ff;
   assign fb_use              = (fb_ff > FB_MAX) ? FB_MAX : fb_ff;
   assign status.bounce_limit = (bounce_ff > MAX_BOUNCE) ? MAX_BOUNCE : bounce_ff;

   // percent to q15 gain by reciprocal multiply
   assign gain_wide = {{(32-FB_W){1'b0}}, fb_use} * GAIN_RECIP;
   assign gain_now  = gain_wide[16+GAIN_W-1:16];

   always_ff @(posedge clock) begin
      gain_ff <= gain_now;
   end

   // history store
   assign rd_addr = wp_ff - dist_ff[ADDR_W-1:0];

   mte_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (STORE_DEPTH)
   ) u_history (
      .clock   (clock),
      .wr_en   (cmd.store),
      .wr_addr (wp_ff),
      .wr_data (x_ff),
      .rd_en   (cmd.read),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      if (dist_ff == '0) begin
         tap_src_in = TAP_CURRENT;
      end else if (dist_ff <= seen_ff) begin
         tap_src_in = TAP_HIST;
      end else begin
         tap_src_in = TAP_ZERO;
      end
   end

   always_comb begin
      case (tap_src_ff)
         TAP_HIST:    tap_val = $signed(rd_data);
         TAP_CURRENT: tap_val = x_ff;
         default:     tap_val = '0;
      endcase
   end

   assign tap_prod   = tap_val * $signed({1'b0, power_ff});
   assign power_prod = power_ff * gain_ff;

   assign acc_sum = {acc_ff[SAMPLE_W-1], acc_ff} + {prod_ff[SAMPLE_W-1], prod_ff};
   always_comb begin
      if (acc_sum > $signed({SAT_MAX[SAMPLE_W-1], SAT_MAX})) begin
         acc_sat = SAT_MAX;
      end else if (acc_sum < $signed({SAT_MIN[SAMPLE_W-1], SAT_MIN})) begin
         acc_sat = SAT_MIN;
      end else begin
         acc_sat = acc_sum[SAMPLE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x_ff     <= sample_in;
         last_ff  <= last_in;
         acc_ff   <= sample_in;
         power_ff <= gain_now;
         dist_ff  <= {{(DIST_W-DELAY_W){1'b0}}, delay_use};
      end
      if (cmd.read) begin
         tap_src_ff <= tap_src_in;
      end
      if (cmd.mult) begin
         // floor of product / 65536
         prod_ff  <= tap_prod[31:16];
         power_ff <= {1'b0, power_prod[2*GAIN_W-1:16]};
         dist_ff  <= dist_ff + {{(DIST_W-DELAY_W){1'b0}}, delay_use};
      end
      if (cmd.accum) begin
         acc_ff <= acc_sat;
      end
      if (cmd.store) begin
         sample_out_ff <= acc_ff;
         last_out_ff   <= last_ff;
      end
   end

   // buffer position
   always_comb begin
      wp_in   = wp_ff;
      seen_in = seen_ff;
      if (cmd.store) begin
         if (last_ff) begin
            wp_in   = '0;
            seen_in = '0;
         end else begin
            wp_in = wp_ff + ADDR_W'(1);
            if (seen_ff < SEEN_MAX) begin
               seen_in = seen_ff + SEEN_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff   <= '0;
         seen_ff <= '0;
      end else begin
         wp_ff   <= wp_in;
         seen_ff <= seen_in;
      end
   end

   assign sample_out = sample_out_ff;
   assign last_out   = last_out_ff;

endmodule

`default_nettype wire

FILE: design/multi_tap_echo_q15.sv
// Multi-tap echo on signed 16-bit samples with Q15 feedback gain.
// One request transaction carries a sample (req_tdata) and an end-of-buffer
// flag (req_tlast); it yields exactly one response transaction with the
// echoed sample and the same flag. Settings are written through csr_we /
// csr_index / csr_wdata while no sample is in flight: index 0 delay length,
// 1 bounce count, 2 feedback percent.
// Samples are processed one at a time. Each bounce runs through the shared
// tap multiplier in order (history read, multiply, saturating add), and a
// new request is accepted only after the previous sample has been stored.
// A finished response sits in an output register; the next sample is
// accepted and worked on while it waits, and only the final store step holds
// until the receiver takes the previous response.
// Reset (synchronous) clears the settings, the buffer position and the
// sample count; the history memory is not cleared, entries never written in
// the current buffer read as zero.
// The history is one 32768 x 16 memory with a single read and write port.
`default_nettype none

module multi_tap_echo_q15 (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_we,
   input  wire logic [mte_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [mte_pkg::CSR_W-1:0]           csr_wdata,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [mte_pkg::SAMPLE_W-1:0]        req_tdata,  // [15:0] sample_in
   input  wire logic                                req_tlast,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic      [mte_pkg::SAMPLE_W-1:0]        rsp_tdata,  // [15:0] sample_out
   output logic                                     rsp_tlast
);

   import mte_pkg::*;

   ctl_cmd_type                cmd;
   dp_status_type              status;
   logic signed [SAMPLE_W-1:0] sample_out;

   mte_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   mte_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .sample_in  ($signed(req_tdata)),
      .last_in    (req_tlast),
      .cmd        (cmd),
      .status     (status),
      .sample_out (sample_out),
      .last_out   (rsp_tlast)
   );

   assign rsp_tdata = sample_out;

endmodule

`default_nettype wire

FILE: design/mte_checker.sv
// port-level checks for the multi-tap echo block, bound to the top level
`default_nettype none

module mte_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_tvalid,
   input wire logic                           req_tready,
   input wire logic                           rsp_tvalid,
   input wire logic                           rsp_tready,
   input wire logic [mte_pkg::SAMPLE_W-1:0]   rsp_tdata,
   input wire logic                           rsp_tlast
);

   // response held while the receiver stalls
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled response changed or dropped");

   // no response is pending right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // one sample in flight at a time
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while a sample is in flight");

   // a new response only appears out of the store step, never straight from idle
   assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid ##1 rsp_tvalid |-> $past(!req_tready))
      else $error("response produced while idle");

endmodule

bind multi_tap_echo_q15 mte_checker u_mte_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire

FILE: sim/multi_tap_echo_q15_tb.sv
// self-checking testbench for the multi-tap echo block: directed table, then random buffers
`default_nettype none

module multi_tap_echo_q15_tb;
   import mte_pkg::*;

   localparam int CYCLE_LIMIT = 300000;
   localparam int PHASE_ITEMS = 50;
   localparam int RAND_PHASES = 8;
   localparam int DRAIN_CYCLES = 30;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       last;
   } echo_out_type;

   // one directed row: optional new settings, then a sample with an optional known answer
   typedef struct packed {
      logic                       reprogram;
      logic [DELAY_W-1:0]         dly;
      logic [BOUNCE_W-1:0]        bnc;
      logic [FB_W-1:0]            fbk;
      logic signed [SAMPLE_W-1:0] smp;
      logic                       lst;
      logic                       known;
      logic signed [SAMPLE_W-1:0] gold;
   } dir_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index = '0;
   logic [CSR_W-1:0]       csr_wdata = '0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [SAMPLE_W-1:0]    req_tdata = '0;  // [15:0] sample_in
   logic                   req_tlast = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [SAMPLE_W-1:0]    rsp_tdata;       // [15:0] sample_out
   logic                   rsp_tlast;

   // predictor state
   logic signed [SAMPLE_W-1:0] hist_mem [0:STORE_DEPTH-1];
   int                         wr_pos = 0;
   int                         hist_count = 0;
   logic [DELAY_W-1:0]         cfg_delay = '0;
   logic [BOUNCE_W-1:0]        cfg_bounces = '0;
   logic [FB_W-1:0]            cfg_fb = '0;

   echo_out_type echo_due [$];
   bit        no_idle = 1'b0;
   int        err_count = 0;
   int        rsp_count = 0;
   int        item_count = 0;
   int        buf_count = 0;
   int        cfg_count = 0;
   int        cycle_count = 0;

   dir_row_type dir_tab [0:22] = '{
      // after reset: no bounces, output equals input
      '{1'b0, 13'd0, 4'd0, 7'd0, 16'sh7fff, 1'b0, 1'b1, 16'sh7fff},
      '{1'b0, 13'd0, 4'd0, 7'd0, 16'sh8000, 1'b0, 1'b1, 16'sh8000},
      '{1'b0, 13'd0, 4'd0, 7'd0, 16'sd0,    1'b0, 1'b1, 16'sd0},
      '{1'b0, 13'd0, 4'd0, 7'd0, -16'sd1,   1'b1, 1'b1, -16'sd1},
      // zero delay, full feedback: every tap is the current sample, saturates
      '{1'b1, 13'd0, 4'd8, 7'd100, 16'sh7fff, 1'b0, 1'b1, 16'sh7fff},
      '{1'b0, 13'd0, 4'd8, 7'd100, 16'sh8000, 1'b0, 1'b1, 16'sh8000},
      '{1'b0, 13'd0, 4'd8, 7'd100, 16'sd0,    1'b1, 1'b1, 16'sd0},
      // taps before the buffer start read zero
      '{1'b1, 13'd1, 4'd3, 7'd50, 16'sd12345,  1'b0, 1'b1, 16'sd12345},
      '{1'b0, 13'd1, 4'd3, 7'd50, -16'sd20000, 1'b0, 1'b0, 16'sd0},
      '{1'b0, 13'd1, 4'd3, 7'd50, 16'sd100,    1'b0, 1'b0, 16'sd0},
      '{1'b0, 13'd1, 4'd3, 7'd50, 16'sd7,      1'b1, 1'b0, 16'sd0},
      // new buffer sees no history
      '{1'b0, 13'd1, 4'd3, 7'd50, 16'sd5000,   1'b0, 1'b1, 16'sd5000},
      '{1'b0, 13'd1, 4'd3, 7'd50, -16'sd5000,  1'b0, 1'b0, 16'sd0},
      // oversized settings are clamped, taps reach too far back
      '{1'b1, 13'd8191, 4'd15, 7'd127, 16'sh8000, 1'b0, 1'b1, 16'sh8000},
      '{1'b0, 13'd8191, 4'd15, 7'd127, 16'sh7fff, 1'b1, 1'b1, 16'sh7fff},
      // zero feedback: products vanish
      '{1'b1, 13'd2, 4'd2, 7'd0, 16'sd21845,  1'b0, 1'b1, 16'sd21845},
      '{1'b0, 13'd2, 4'd2, 7'd0, -16'sd21846, 1'b0, 1'b1, -16'sd21846},
      '{1'b0, 13'd2, 4'd2, 7'd0, 16'sd1,      1'b1, 1'b1, 16'sd1},
      // history taps driving the adder into saturation
      '{1'b1, 13'd1, 4'd8, 7'd100, 16'sd30000,  1'b0, 1'b1, 16'sd30000},
      '{1'b0, 13'd1, 4'd8, 7'd100, 16'sd30000,  1'b0, 1'b0, 16'sd0},
      '{1'b0, 13'd1, 4'd8, 7'd100, -16'sd30000, 1'b0, 1'b0, 16'sd0},
      '{1'b0, 13'd1, 4'd8, 7'd100, -16'sd30000, 1'b0, 1'b0, 16'sd0},
      '{1'b0, 13'd1, 4'd8, 7'd100, 16'sh8000,   1'b1, 1'b0, 16'sd0}
   };

   multi_tap_echo_q15 i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #1 clock = ~clock;

   // echoed sample for one input, advancing the buffer position
   function automatic echo_out_type echo_predict(input logic signed [SAMPLE_W-1:0] x,
                                                 input logic lst);
      int           delay;
      int           bounces;
      int           fb;
      int           g;
      int           power;
      int           acc;
      int           tap;
      int           tap_dist;
      int           slot;
      echo_out_type r;
      delay   = (cfg_delay > MAX_DELAY) ? int'(MAX_DELAY) : int'(cfg_delay);
      bounces = (cfg_bounces > MAX_BOUNCE) ? int'(MAX_BOUNCE) : int'(cfg_bounces);
      fb      = (cfg_fb > FB_MAX) ? int'(FB_MAX) : int'(cfg_fb);
      g       = fb * 32767 / 100;
      power   = g;
      acc     = x;
      for (int i = 1; i <= bounces; i++) begin
         tap_dist = delay * i;
         if (tap_dist == 0) begin
            tap = x;
         end else if (tap_dist <= hist_count && tap_dist <= STORE_DEPTH) begin
            slot = (wr_pos - tap_dist) & (STORE_DEPTH - 1);
            tap  = hist_mem[slot];
         end else begin
            tap = 0;
         end
         // arithmetic shift keeps the floor of the upper half
         acc = acc + ((tap * power) >>> 16);
         if (acc > 32767) acc = 32767;
         if (acc < -32768) acc = -32768;
         power = (power * g) >>> 16;
      end
      hist_mem[wr_pos] = x;
      if (lst) begin
         wr_pos     = 0;
         hist_count = 0;
      end else begin
         wr_pos = (wr_pos + 1) & (STORE_DEPTH - 1);
         if (hist_count < STORE_DEPTH) hist_count++;
      end
      r.sample = acc[SAMPLE_W-1:0];
      r.last   = lst;
      return r;
   endfunction

   task automatic write_csr(input csr_index_type idx, input logic [CSR_W-1:0] val);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_we = 1'b0;
      case (idx)
         CSR_DELAY:    cfg_delay = val[DELAY_W-1:0];
         CSR_BOUNCE:   cfg_bounces = val[BOUNCE_W-1:0];
         CSR_FEEDBACK: cfg_fb = val[FB_W-1:0];
         default: ;
      endcase
   endtask

   // wait until every response is back and the block has settled
   task automatic drain;
      req_tvalid = 1'b0;
      while (echo_due.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic set_echo(input logic [DELAY_W-1:0] d, input logic [BOUNCE_W-1:0] b,
                           input logic [FB_W-1:0] f);
      drain();
      write_csr(CSR_DELAY, CSR_W'(d));
      write_csr(CSR_BOUNCE, CSR_W'(b));
      write_csr(CSR_FEEDBACK, CSR_W'(f));
      cfg_count++;
   endtask

   task automatic send_sample(input logic signed [SAMPLE_W-1:0] x, input logic lst,
                              input logic known, input logic signed [SAMPLE_W-1:0] gold);
      echo_out_type e;
      while (!no_idle && $urandom_range(99) < 32) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = x;
      req_tlast  = lst;
      do @(posedge clock); while (!req_tready);
      e = echo_predict(x, lst);
      if (known) e.sample = gold;
      echo_due.push_back(e);
      item_count++;
      if (lst) buf_count++;
      @(negedge clock);
   endtask

   always @(negedge clock) begin
      rsp_tready = no_idle || ($urandom_range(99) >= 32);
   end

   always @(posedge clock) begin
      echo_out_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsp_count++;
         if (echo_due.size() == 0) begin
            $error("response transaction with no sample outstanding");
            err_count++;
         end else begin
            e = echo_due.pop_front();
            if (rsp_tdata !== e.sample) begin
               $error("sample_out: expected %0d, got %0d", e.sample, $signed(rsp_tdata));
               err_count++;
            end
            if (rsp_tlast !== e.last) begin
               $error("last_out: expected %0b, got %0b", e.last, rsp_tlast);
               err_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses pending", cycle_count,
                  echo_due.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      logic [DELAY_W-1:0]         d;
      logic [BOUNCE_W-1:0]        b;
      logic [FB_W-1:0]            f;
      logic signed [SAMPLE_W-1:0] x;
      repeat (2) @(negedge clock);
      reset = 1'b0;

      foreach (dir_tab[k]) begin
         if (dir_tab[k].reprogram) set_echo(dir_tab[k].dly, dir_tab[k].bnc, dir_tab[k].fbk);
         send_sample(dir_tab[k].smp, dir_tab[k].lst, dir_tab[k].known, dir_tab[k].gold);
      end

      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         case ($urandom_range(9))
            0:       d = '0;
            1:       d = DELAY_W'($urandom_range(4097, 8191));
            2:       d = DELAY_W'($urandom_range(20, 60));
            default: d = DELAY_W'($urandom_range(1, 8));
         endcase
         b = BOUNCE_W'($urandom_range(0, 15));
         f = FB_W'($urandom_range(0, 127));
         if (ph == 0) begin
            d = MAX_DELAY;
            b = MAX_BOUNCE;
            f = FB_MAX;
         end
         set_echo(d, b, f);
         // a long stretch where neither side holds back
         no_idle = (ph == 3 || ph == 4);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            case ($urandom_range(7))
               0:       x = 16'sh7fff;
               1:       x = 16'sh8000;
               2:       x = SAMPLE_W'($urandom_range(0, 200) - 100);
               default: x = SAMPLE_W'($urandom_range(65535));
            endcase
            send_sample(x, ($urandom_range(15) == 0), 1'b0, '0);
         end
      end
      no_idle = 1'b0;

      drain();
      $display("sent %0d samples in %0d closed buffers under %0d echo settings",
               item_count, buf_count, cfg_count);
      $display("checked %0d responses, %0d mismatches", rsp_count, err_count);
      if (err_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire

FILE: multi_tap_echo_q15.f
design/mte_pkg.sv
design/mte_ram.sv
design/mte_ctrl.sv
design/mte_datapath.sv
design/multi_tap_echo_q15.sv
design/mte_checker.sv
sim/multi_tap_echo_q15_tb.sv
